FILE: sv/prc_pkg.sv
package prc_pkg;

  // Component format
  localparam int CB      = 20;
  localparam int FB      = 12;
  localparam int VEC_W   = 3 * CB;
  // Scalar input formats
  localparam int IM_W    = 16;
  localparam int TOT_W   = IM_W + 1;
  localparam int E_W     = 13;
  localparam int E_FB    = 12;
  localparam int FD_W    = 16;
  localparam int FD_FB   = 16;
  localparam int PEN_W   = 20;
  // Internal widths
  localparam int DIFF_W  = CB + 1;
  localparam int PROD_W  = DIFF_W + CB;
  localparam int DOT_W   = PROD_W + 2;
  localparam int TB_W    = DOT_W + 1 + E_W + 1;
  localparam int AB_W    = DOT_W + FD_W + 1;
  localparam int ACCS_W  = AB_W - FD_FB;
  localparam int CB_W    = ACCS_W + E_W + 1;
  localparam int TG_W    = TB_W - E_FB + 2;
  localparam int DELTA_W = DOT_W + 1;
  localparam int DIV_W   = DELTA_W + IM_W;
  localparam int REM_W   = TOT_W;
  localparam int Q_W     = DELTA_W - FB;
  localparam int SAT_W   = CB + Q_W + 4;
  // Stream word widths
  localparam int IN_W    = 5 * VEC_W + 2 * IM_W + E_W + PEN_W;
  localparam int IN_TW   = ((IN_W + 7) / 8) * 8;
  localparam int OUT_TW  = 4 * VEC_W;
  localparam logic [FD_W-1:0] FD_RESET = FD_W'(1092);

  typedef logic [2:0][CB-1:0] vec_t;

  // Per-contact operands carried along the front pipe
  typedef struct packed {
    vec_t             va;
    vec_t             vb;
    vec_t             n;
    logic [IM_W-1:0]  ima;
    logic [IM_W-1:0]  imb;
    logic [E_W-1:0]   e;
    logic [PEN_W-1:0] pen;
  } ctx_t;

  // Word handed from front to back
  typedef struct packed {
    vec_t              va;
    vec_t              vb;
    vec_t              n;
    logic [DELTA_W-1:0] delta;
    logic [PEN_W-1:0]  pen;
    logic [TOT_W-1:0]  total;
    logic [DIV_W-1:0]  vdiv;
    logic [DIV_W-1:0]  pdiv;
    logic              vflag;
    logic              pflag;
  } fb_t;

  // Clamp to the signed component range
  function automatic logic [CB-1:0] sat(input logic signed [SAT_W-1:0] x);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'((64'sd1 <<< (CB - 1)) - 64'sd1);
    lo = -hi - SAT_W'(1);
    if (x > hi) sat = hi[CB-1:0];
    else if (x < lo) sat = lo[CB-1:0];
    else sat = x[CB-1:0];
  endfunction

endpackage

FILE: sv/prc_front.sv
module prc_front
  import prc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  ctx_t            ctx_i,
  input  vec_t            acc_a_i,
  input  vec_t            acc_b_i,
  input  logic [FD_W-1:0] fd_i,
  input  logic            full_i,
  output logic            push_o,
  output fb_t             word_o
);

  logic en;
  logic [5:0] vld_q;
  ctx_t ctx_q [6];

  logic signed [PROD_W-1:0] dvp_q [3];
  logic signed [PROD_W-1:0] dap_q [3];
  logic signed [DOT_W-1:0]  sep_q [3];
  logic signed [DOT_W-1:0]  acc_q;
  logic signed [TG_W-1:0]   tgt0_q [2];
  logic signed [ACCS_W-1:0] accs_q;
  logic                     accneg_q;
  logic signed [TG_W-1:0]   corr_q;
  logic [DELTA_W-1:0]       delta_q;
  logic                     vflag_q, pflag_q;
  logic [DIV_W-1:0]         vdiv_q, pdiv_q;
  logic                     vflag6_q, pflag6_q;
  logic [DELTA_W-1:0]       delta6_q;

  // Whole front advances together while the queue has room
  assign en      = !full_i;
  assign ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  // Stage 1: component differences times normal
  logic signed [PROD_W-1:0] dvp_d [3];
  logic signed [PROD_W-1:0] dap_d [3];
  always_comb begin
    logic signed [DIFF_W-1:0] dv, da;
    for (int i = 0; i < 3; i++) begin
      dv = DIFF_W'($signed(ctx_i.va[i])) - DIFF_W'($signed(ctx_i.vb[i]));
      dvp_d[i] = PROD_W'(dv) * PROD_W'($signed(ctx_i.n[i]));
      da = DIFF_W'($signed(acc_a_i[i])) - DIFF_W'($signed(acc_b_i[i]));
      dap_d[i] = PROD_W'(da) * PROD_W'($signed(ctx_i.n[i]));
    end
  end

  // Stage 3 and 4 arithmetic
  logic signed [TG_W-1:0]   tgt0_d;
  logic signed [ACCS_W-1:0] accs_d;
  logic signed [TG_W-1:0]   corr_d;
  always_comb begin
    logic signed [TB_W-1:0] tb;
    logic signed [AB_W-1:0] ab;
    logic signed [CB_W-1:0] cb;
    tb = TB_W'(-(DOT_W + 1)'(sep_q[0])) * TB_W'($signed({1'b0, ctx_q[1].e}));
    tgt0_d = TG_W'(tb >>> E_FB);
    ab = AB_W'(acc_q) * AB_W'($signed({1'b0, fd_i}));
    accs_d = ACCS_W'(ab >>> FD_FB);
    cb = CB_W'($signed({1'b0, ctx_q[2].e})) * CB_W'(accs_q);
    corr_d = TG_W'(cb >>> E_FB);
  end

  // Stage 5: target, clamp and velocity change
  logic [DELTA_W-1:0] delta_d;
  always_comb begin
    logic signed [TG_W-1:0] tgt;
    tgt = tgt0_q[1];
    if (accneg_q) begin
      tgt = tgt + corr_q;
      if (tgt < 0) tgt = '0;
    end
    delta_d = DELTA_W'(tgt - TG_W'(sep_q[2]));
  end

  logic [TOT_W-1:0] tot4;
  assign tot4 = TOT_W'(ctx_q[3].ima) + TOT_W'(ctx_q[3].imb);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx_q[0] <= ctx_i;
      for (int k = 1; k < 6; k++) ctx_q[k] <= ctx_q[k-1];
      for (int i = 0; i < 3; i++) begin
        dvp_q[i] <= dvp_d[i];
        dap_q[i] <= dap_d[i];
      end
      sep_q[0] <= DOT_W'(dvp_q[0]) + DOT_W'(dvp_q[1]) + DOT_W'(dvp_q[2]);
      acc_q    <= DOT_W'(dap_q[0]) + DOT_W'(dap_q[1]) + DOT_W'(dap_q[2]);
      for (int k = 1; k < 3; k++) sep_q[k] <= sep_q[k-1];
      tgt0_q[0] <= tgt0_d;
      tgt0_q[1] <= tgt0_q[0];
      accs_q    <= accs_d;
      accneg_q  <= (accs_q < 0);
      corr_q    <= corr_d;
      delta_q   <= delta_d;
      vflag_q   <= (sep_q[2] <= 0) && (tot4 != '0);
      pflag_q   <= ($signed(ctx_q[3].pen) > 0) && (tot4 != '0);
      vdiv_q    <= DIV_W'(delta_q) * DIV_W'(ctx_q[4].ima);
      pdiv_q    <= DIV_W'(ctx_q[4].pen[PEN_W-2:0]) * DIV_W'(ctx_q[4].ima);
      delta6_q  <= delta_q;
      vflag6_q  <= vflag_q;
      pflag6_q  <= pflag_q;
    end
  end

  // Hand the finished word to the queue
  assign push_o = en && vld_q[5];
  always_comb begin
    word_o.va    = ctx_q[5].va;
    word_o.vb    = ctx_q[5].vb;
    word_o.n     = ctx_q[5].n;
    word_o.delta = delta6_q;
    word_o.pen   = ctx_q[5].pen;
    word_o.total = TOT_W'(ctx_q[5].ima) + TOT_W'(ctx_q[5].imb);
    word_o.vdiv  = vdiv_q;
    word_o.pdiv  = pdiv_q;
    word_o.vflag = vflag6_q;
    word_o.pflag = pflag6_q;
  end

endmodule

FILE: sv/prc_fifo.sv
module prc_fifo
  import prc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  fb_t  word_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output fb_t  word_o
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  fb_t              mem [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [PTR_W:0]   cnt_q;
  logic             do_pop;

  assign full_o  = (cnt_q == (PTR_W + 1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_pop  = pop_i && !empty_o;
  assign word_o  = mem[rptr_q];

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (push_i) mem[wptr_q] <= word_i;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + PTR_W'(1);
      if (do_pop) rptr_q <= rptr_q + PTR_W'(1);
      cnt_q <= cnt_q + (PTR_W + 1)'(push_i) - (PTR_W + 1)'(do_pop);
    end
  end

endmodule

FILE: sv/prc_divider.sv
module prc_divider
  import prc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  fb_t              word_i,
  output logic             valid_o,
  output fb_t              word_o,
  output logic [REM_W-1:0] vrem_o,
  output logic [REM_W-1:0] prem_o
);

  // One quotient bit per stage for both divisions; the dividend
  // shifts out of vdiv/pdiv while the quotient shifts in.
  logic [DIV_W-1:0] vld_q;
  fb_t              wd_q   [DIV_W];
  logic [REM_W-1:0] vrem_q [DIV_W];
  logic [REM_W-1:0] prem_q [DIV_W];

  fb_t              wd_d   [DIV_W];
  logic [REM_W-1:0] vrem_d [DIV_W];
  logic [REM_W-1:0] prem_d [DIV_W];

  always_comb begin
    fb_t              src;
    logic [REM_W-1:0] vr, pr;
    logic [REM_W:0]   tv, tp, dv;
    for (int k = 0; k < DIV_W; k++) begin
      if (k == 0) begin
        src = word_i;
        vr  = '0;
        pr  = '0;
      end else begin
        src = wd_q[k-1];
        vr  = vrem_q[k-1];
        pr  = prem_q[k-1];
      end
      dv = {1'b0, src.total};
      tv = {vr, src.vdiv[DIV_W-1]};
      tp = {pr, src.pdiv[DIV_W-1]};
      wd_d[k] = src;
      wd_d[k].vdiv = {src.vdiv[DIV_W-2:0], tv >= dv};
      wd_d[k].pdiv = {src.pdiv[DIV_W-2:0], tp >= dv};
      vrem_d[k] = (tv >= dv) ? REM_W'(tv - dv) : REM_W'(tv);
      prem_d[k] = (tp >= dv) ? REM_W'(tp - dv) : REM_W'(tp);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DIV_W-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DIV_W; k++) begin
        wd_q[k]   <= wd_d[k];
        vrem_q[k] <= vrem_d[k];
        prem_q[k] <= prem_d[k];
      end
    end
  end

  assign valid_o = vld_q[DIV_W-1];
  assign word_o  = wd_q[DIV_W-1];
  assign vrem_o  = vrem_q[DIV_W-1];
  assign prem_o  = prem_q[DIV_W-1];

endmodule

FILE: sv/prc_back.sv
module prc_back
  import prc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  output logic              pop_o,
  input  fb_t               word_i,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_TW-1:0] m_axis_tdata,
  output logic [1:0]        m_axis_tuser
);

  logic             en;
  logic             dvld;
  fb_t              dw;
  logic [REM_W-1:0] vrem, prem;

  logic [1:0]   vld_q;
  logic         out_vld_q;

  // Back advances whenever the output word is free or being taken
  assign en    = !out_vld_q || m_axis_tready;
  assign pop_o = en && !empty_i;

  prc_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pop_o),
    .word_i  (word_i),
    .valid_o (dvld),
    .word_o  (dw),
    .vrem_o  (vrem),
    .prem_o  (prem)
  );

  // Stage 1: per-particle shares
  fb_t                b1_q;
  logic [Q_W-1:0]     qa_q, qb_q;
  logic [PEN_W-1:0]   pa_q, pb_q;
  logic [DELTA_W-1:0] qbf;
  logic [PEN_W-1:0]   pbf;

  always_comb begin
    qbf = dw.delta - dw.vdiv[DELTA_W-1:0] - DELTA_W'(vrem != '0);
    pbf = dw.pen - dw.pdiv[PEN_W-1:0] - PEN_W'(prem != '0);
  end

  // Stage 2: apply along the normal
  logic [2:0][CB-1:0] nva_q, nvb_q, sa_q, sb_q;
  logic               vf2_q, pf2_q;
  logic signed [SAT_W-1:0] nva_d [3], nvb_d [3], sa_d [3], sb_d [3];

  always_comb begin
    logic signed [CB+Q_W:0]   pv;
    logic signed [CB+PEN_W-1:0] pp;
    for (int i = 0; i < 3; i++) begin
      pv = (CB + Q_W + 1)'($signed(b1_q.n[i])) * (CB + Q_W + 1)'($signed({1'b0, qa_q}));
      nva_d[i] = SAT_W'($signed(b1_q.va[i])) + SAT_W'(pv >>> FB);
      pv = -((CB + Q_W + 1)'($signed(b1_q.n[i])) * (CB + Q_W + 1)'($signed({1'b0, qb_q})));
      nvb_d[i] = SAT_W'($signed(b1_q.vb[i])) + SAT_W'(pv >>> FB);
      pp = (CB + PEN_W)'($signed(b1_q.n[i])) * (CB + PEN_W)'($signed(pa_q));
      sa_d[i] = SAT_W'(pp >>> FB);
      pp = -((CB + PEN_W)'($signed(b1_q.n[i])) * (CB + PEN_W)'($signed(pb_q)));
      sb_d[i] = SAT_W'(pp >>> FB);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[0], dvld};
      out_vld_q <= vld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_q <= dw;
      qa_q <= dw.vdiv[FB+Q_W-1:FB];
      qb_q <= qbf[DELTA_W-1:FB];
      pa_q <= dw.pdiv[PEN_W-1:0];
      pb_q <= pbf;
      for (int i = 0; i < 3; i++) begin
        nva_q[i] <= b1_q.vflag ? sat(nva_d[i]) : b1_q.va[i];
        nvb_q[i] <= b1_q.vflag ? sat(nvb_d[i]) : b1_q.vb[i];
        sa_q[i]  <= b1_q.pflag ? sat(sa_d[i]) : '0;
        sb_q[i]  <= b1_q.pflag ? sat(sb_d[i]) : '0;
      end
      vf2_q <= b1_q.vflag;
      pf2_q <= b1_q.pflag;
    end
  end

  // Output word register
  assign m_axis_tvalid = out_vld_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata <= {sb_q, sa_q, nvb_q, nva_q};
      m_axis_tuser <= {pf2_q, vf2_q};
    end
  end

endmodule

FILE: sv/particle_contact_resolver_core.sv
// Pipeline: an input word passes through 6 front stages, the queue,
// a 60-stage restoring divider and 3 back stages to the output word.
// Throughput: one contact per cycle while the output is not stalled; the divider takes one quotient bit per stage.
// Reset: rst_ni clears all valid flags and queue pointers and loads
// frame_duration with 1092; no clearing pass.
module particle_contact_resolver_core
  import prc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // velocity_a, velocity_b, acceleration_a, acceleration_b, contact_normal,
  // inverse_mass_a, inverse_mass_b, restitution, penetration, zero pad
  input  logic [IN_TW-1:0]  s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // new_velocity_a, new_velocity_b, position_shift_a, position_shift_b
  output logic [OUT_TW-1:0] m_axis_tdata,
  // velocity_changed, position_changed
  output logic [1:0]        m_axis_tuser,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [FD_W-1:0]   cfg_data_i
);

  logic [FD_W-1:0] fd_q;
  ctx_t            ctx;
  logic            full, push, empty, pop;
  fb_t             qin, qout;

  // Hold frame duration
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fd_q <= FD_RESET;
    else if (cfg_valid_i) fd_q <= cfg_data_i;
  end

  // Unpack the input word
  assign ctx.va  = s_axis_tdata[VEC_W-1:0];
  assign ctx.vb  = s_axis_tdata[2*VEC_W-1:VEC_W];
  assign ctx.n   = s_axis_tdata[5*VEC_W-1:4*VEC_W];
  assign ctx.ima = s_axis_tdata[5*VEC_W+IM_W-1:5*VEC_W];
  assign ctx.imb = s_axis_tdata[5*VEC_W+2*IM_W-1:5*VEC_W+IM_W];
  assign ctx.e   = s_axis_tdata[5*VEC_W+2*IM_W+E_W-1:5*VEC_W+2*IM_W];
  assign ctx.pen = s_axis_tdata[IN_W-1:IN_W-PEN_W];

  prc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .ctx_i     (ctx),
    .acc_a_i   (s_axis_tdata[3*VEC_W-1:2*VEC_W]),
    .acc_b_i   (s_axis_tdata[4*VEC_W-1:3*VEC_W]),
    .fd_i      (fd_q),
    .full_i    (full),
    .push_o    (push),
    .word_o    (qin)
  );

  prc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .word_i  (qin),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .word_o  (qout)
  );

  prc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .pop_o         (pop),
    .word_i        (qout),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

FILE: dv/prc_checker.sv
module prc_checker
  import prc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [IN_TW-1:0]  s_axis_tdata,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [OUT_TW-1:0] m_axis_tdata,
  input  logic [1:0]        m_axis_tuser,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_o,
  input  logic [FD_W-1:0]   cfg_data_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                vel_hits_o,
  output int                pos_hits_o
);

  typedef struct packed {
    logic [VEC_W-1:0] vel_a;
    logic [VEC_W-1:0] vel_b;
    logic [VEC_W-1:0] shift_a;
    logic [VEC_W-1:0] shift_b;
    logic             vel_chg;
    logic             pos_chg;
  } contact_res_t;

  contact_res_t    resolved_q[$];
  logic [FD_W-1:0] frame_dur;

  assign pending_o = resolved_q.size();

  // Clamp to the signed component range
  function automatic logic [CB-1:0] clamp_comp(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (CB - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[CB-1:0];
  endfunction

  // Resolve one contact word against the current frame duration
  function automatic contact_res_t resolve_contact(input logic [IN_TW-1:0] w,
                                                   input logic [FD_W-1:0] fd);
    contact_res_t r;
    longint va[3], vb[3], nrm[3];
    longint sep, acc, target, acc_sep, delta, qa, qb, pa, pb;
    longint ima, imb, total, e, pen;
    sep = 0;
    acc = 0;
    ima = longint'(w[5*VEC_W +: IM_W]);
    imb = longint'(w[5*VEC_W+IM_W +: IM_W]);
    total = ima + imb;
    e = longint'(w[5*VEC_W+2*IM_W +: E_W]);
    pen = longint'($signed(w[5*VEC_W+2*IM_W+E_W +: PEN_W]));
    for (int i = 0; i < 3; i++) begin
      va[i]  = longint'($signed(w[i*CB +: CB]));
      vb[i]  = longint'($signed(w[VEC_W+i*CB +: CB]));
      nrm[i] = longint'($signed(w[4*VEC_W+i*CB +: CB]));
      sep += (va[i] - vb[i]) * nrm[i];
      acc += (longint'($signed(w[2*VEC_W+i*CB +: CB]))
              - longint'($signed(w[3*VEC_W+i*CB +: CB]))) * nrm[i];
    end
    r.vel_chg = 1'b0;
    r.pos_chg = 1'b0;
    for (int i = 0; i < 3; i++) begin
      r.vel_a[i*CB +: CB]   = clamp_comp(va[i]);
      r.vel_b[i*CB +: CB]   = clamp_comp(vb[i]);
      r.shift_a[i*CB +: CB] = '0;
      r.shift_b[i*CB +: CB] = '0;
    end
    // Closing contact: bounce, drop frame build-up, share by inverse mass
    if (sep <= 0 && total != 0) begin
      target = (-sep * e) >>> E_FB;
      acc_sep = (acc * longint'(fd)) >>> FD_FB;
      if (acc_sep < 0) begin
        target += (e * acc_sep) >>> E_FB;
        if (target < 0) target = 0;
      end
      delta = target - sep;
      qa = (delta * ima / total) >>> FB;
      qb = (delta * imb / total) >>> FB;
      for (int i = 0; i < 3; i++) begin
        r.vel_a[i*CB +: CB] = clamp_comp(va[i] + ((nrm[i] * qa) >>> FB));
        r.vel_b[i*CB +: CB] = clamp_comp(vb[i] + ((-nrm[i] * qb) >>> FB));
      end
      r.vel_chg = 1'b1;
    end
    // Penetration: push the pair apart along the normal
    if (pen > 0 && total != 0) begin
      pa = pen * ima / total;
      pb = pen * imb / total;
      for (int i = 0; i < 3; i++) begin
        r.shift_a[i*CB +: CB] = clamp_comp((nrm[i] * pa) >>> FB);
        r.shift_b[i*CB +: CB] = clamp_comp((-nrm[i] * pb) >>> FB);
      end
      r.pos_chg = 1'b1;
    end
    return r;
  endfunction

  task automatic report(input string what, input logic [VEC_W-1:0] got,
                        input logic [VEC_W-1:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    vel_hits_o = 0;
    pos_hits_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    contact_res_t want;
    if (!rst_ni) begin
      frame_dur <= FD_RESET;
    end else begin
      // Track register writes
      if (cfg_valid_i && cfg_ready_o) frame_dur <= cfg_data_i;
      // Compare the output word with the oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        if (resolved_q.size() == 0) begin
          report("unexpected word", m_axis_tdata[VEC_W-1:0], '0);
        end else begin
          want = resolved_q.pop_front();
          if (m_axis_tdata[0 +: VEC_W] !== want.vel_a)
            report("new_velocity_a", m_axis_tdata[0 +: VEC_W], want.vel_a);
          if (m_axis_tdata[VEC_W +: VEC_W] !== want.vel_b)
            report("new_velocity_b", m_axis_tdata[VEC_W +: VEC_W], want.vel_b);
          if (m_axis_tdata[2*VEC_W +: VEC_W] !== want.shift_a)
            report("position_shift_a", m_axis_tdata[2*VEC_W +: VEC_W], want.shift_a);
          if (m_axis_tdata[3*VEC_W +: VEC_W] !== want.shift_b)
            report("position_shift_b", m_axis_tdata[3*VEC_W +: VEC_W], want.shift_b);
          if (m_axis_tuser[0] !== want.vel_chg)
            report("velocity_changed", VEC_W'(m_axis_tuser[0]), VEC_W'(want.vel_chg));
          if (m_axis_tuser[1] !== want.pos_chg)
            report("position_changed", VEC_W'(m_axis_tuser[1]), VEC_W'(want.pos_chg));
          vel_hits_o += want.vel_chg;
          pos_hits_o += want.pos_chg;
        end
      end
      // Predict each accepted contact
      if (s_axis_tvalid && s_axis_tready)
        resolved_q.push_back(resolve_contact(s_axis_tdata, frame_dur));
    end
  end

endmodule

FILE: dv/tb.sv
module tb;
  import prc_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_TW-1:0]  s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_TW-1:0] m_axis_tdata;
  logic [1:0]        m_axis_tuser;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [FD_W-1:0]   cfg_data_i = '0;
  int                fail_count, pending, vel_hits, pos_hits;
  int                sent = 0;
  int                quiet_cycles = 0;
  int                burst_left = 0;
  int                sink_mode = 0;

  always #5 clk_i = ~clk_i;

  particle_contact_resolver_core uut (.*);

  prc_checker chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending),
    .vel_hits_o(vel_hits), .pos_hits_o(pos_hits)
  );

  // Stall the output on a pattern that changes at random
  always @(posedge clk_i) begin
    if ($urandom_range(0, 299) == 0) sink_mode <= $urandom_range(0, 3);
    case (sink_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= ($urandom_range(0, 9) == 0);
      default: m_axis_tready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog expired with %0d words outstanding", pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [CB-1:0] rand_comp(input int mode);
    case (mode)
      0: return CB'($urandom);
      1: return CB'($urandom_range(0, 16383) - 8192);
      2: case ($urandom_range(0, 2))
           0: return {1'b0, {(CB-1){1'b1}}};
           1: return {1'b1, {(CB-1){1'b0}}};
           default: return '0;
         endcase
      default: return CB'($urandom_range(0, 1023) - 512);
    endcase
  endfunction

  function automatic logic [VEC_W-1:0] rand_vec(input int mode);
    return {rand_comp(mode), rand_comp(mode), rand_comp(mode)};
  endfunction

  // Mostly unit normals along an axis, sometimes arbitrary
  function automatic logic [VEC_W-1:0] rand_normal();
    logic [VEC_W-1:0] v;
    int axis;
    if ($urandom_range(0, 3) == 0) return rand_vec($urandom_range(0, 3));
    v = '0;
    axis = $urandom_range(0, 2);
    v[axis*CB +: CB] = $urandom_range(0, 1) ? CB'(4096) : -CB'(4096);
    return v;
  endfunction

  function automatic logic [IN_TW-1:0] pack_contact(
      input logic [VEC_W-1:0] va, vb, aa, ab, nrm,
      input logic [IM_W-1:0] ima, imb, input logic [E_W-1:0] e,
      input logic [PEN_W-1:0] pen);
    return IN_TW'({pen, e, imb, ima, nrm, ab, aa, vb, va});
  endfunction

  function automatic logic [IN_TW-1:0] rand_contact();
    int mode;
    logic [IM_W-1:0] ima, imb;
    mode = $urandom_range(0, 3);
    ima = $urandom_range(0, 7) == 0 ? '0 : IM_W'($urandom);
    imb = $urandom_range(0, 7) == 0 ? '0 : IM_W'($urandom);
    return pack_contact(rand_vec(mode), rand_vec(mode), rand_vec($urandom_range(0, 3)),
                        rand_vec($urandom_range(0, 3)), rand_normal(), ima, imb,
                        $urandom_range(0, 3) == 0 ? E_W'($urandom) : E_W'($urandom_range(0, 4096)),
                        PEN_W'($urandom));
  endfunction

  // Hold the word until accepted, sending in bursts with idle gaps between bursts
  task automatic send_contact(input logic [IN_TW-1:0] w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_frame_duration(input logic [FD_W-1:0] fd);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= fd;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  localparam logic [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};
  localparam logic [CB-1:0] C_ONE = CB'(4096);

  initial begin
    logic [FD_W-1:0] settings[5];
    logic [VEC_W-1:0] vmax, vmin, nx;
    settings = '{16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd1092};
    settings[3] = FD_W'($urandom);
    vmax = {C_MAX, C_MAX, C_MAX};
    vmin = {C_MIN, C_MIN, C_MIN};
    nx = {{(2*CB){1'b0}}, C_ONE};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed contacts under the reset frame duration
    send_contact('0);
    send_contact(pack_contact(vmin, vmax, '0, '0, nx, 16'h1000, 16'h1000, 13'd4096, 20'd4096));
    send_contact(pack_contact(vmin, vmax, '0, '0, nx, '0, '0, 13'd4096, 20'd4096));
    send_contact(pack_contact(vmax, vmin, '0, '0, nx, 16'h1000, 16'h1000, 13'd4096, 20'd4096));
    send_contact(pack_contact(vmin, vmax, vmin, vmax, vmax, 16'hFFFF, 16'hFFFF,
                              13'h1FFF, 20'h7FFFF));
    send_contact(pack_contact(vmin, vmax, vmin, vmax, vmin, 16'hFFFF, 16'd0,
                              13'd0, 20'h80000));
    send_contact(pack_contact(vmax, vmin, vmax, vmin, vmin, 16'd0, 16'hFFFF,
                              13'h1FFF, 20'hFFFFF));
    send_contact(pack_contact(-nx, '0, vmin, vmax, nx, 16'h1000, 16'h3000,
                              13'd2048, 20'd1));
    send_contact(pack_contact('0, '0, -nx, nx, nx, 16'h1000, 16'h1000, 13'd4096, 20'd0));
    send_contact(pack_contact(vmax, vmax, vmin, vmin, vmax, 16'd1, 16'd1, 13'd8191, 20'd100));
    send_contact(pack_contact({(VEC_W){1'b1}}, '0, '0, {(VEC_W){1'b1}},
                              {(VEC_W){1'b1}}, 16'hFFFF, 16'hFFFF, 13'h1FFF, 20'hFFFFF));
    send_contact(pack_contact(vmin, vmax, '0, '0, vmax, 16'h8000, 16'h8000, 13'd4096,
                              20'h7FFFF));
    for (int i = 0; i < 10; i++) send_contact(rand_contact());

    // Random contacts over a sweep of frame durations
    foreach (settings[p]) begin
      drain();
      write_frame_duration(settings[p]);
      for (int i = 0; i < 250; i++) send_contact(rand_contact());
    end
    drain();

    $display("%0d contacts over 6 frame durations incl. 0 and 65535", sent);
    $display("%0d impulses and %0d penetration fixes resolved", vel_hits, pos_hits);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: particle_contact_resolver_core.f
sv/prc_pkg.sv
sv/prc_front.sv
sv/prc_fifo.sv
sv/prc_divider.sv
sv/prc_back.sv
sv/particle_contact_resolver_core.sv
dv/prc_checker.sv
dv/tb.sv
